// ----- rtl/lrutc_pkg.sv -----
// Package for the move-to-front tag cache: capacity, field widths and the
// stored entry type. Depends on nothing; used by lru_move_to_front_tag_cache_unit.
`timescale 1ns / 1ps
`default_nettype none

package lrutc_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CODE_W   = 21;
  localparam int SLOT_W   = 7;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  slot;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/lru_move_to_front_tag_cache_unit.sv -----
// Top level of the move-to-front tag cache: recency memory, scan sequencer
// and result register. Depends on lrutc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative tag cache with least-recently-used replacement. Each
// input beat carries one 21-bit character code; each produces exactly one
// output beat with the hit flag, the slot number, and, on a miss in a full
// cache, the evicted code. Entries live in a single-port memory in recency
// order, front first. One shared comparator walks the list entry by entry
// (read, then compare) and, in the same pass, writes each entry it passes
// one place toward the back, so the move-to-front costs no extra sweep.
// The walk stops at the hit or at the end of the list, and a miss that
// appends to a list that is not full passes through the tail state as well.
// The worst case is a miss in a full cache, which walks the whole list; the
// registered read of the recency memory is why each entry needs a read
// state before its compare state. The input is not ready while a request
// is being worked on. A finished result waits in the output register, and
// the block takes the next request while it waits; that request's front
// write holds off until the output register is free. No clearing pass is
// needed after reset: only entries below the entry count are read.
module lru_move_to_front_tag_cache_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [lrutc_pkg::IN_W-1:0]   s_tdata,   // [20:0] code, [23:21] zero
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [lrutc_pkg::OUT_W-1:0]  m_tdata    // [0] hit, [7:1] slot, [8] evicted,
                                                  // [29:9] evicted_code, [31:30] zero
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_TAIL,
    ST_FRONT
  } state_t;

  state_t state;

  // Recency list, front at address zero.
  lrutc_pkg::entry_t mem [lrutc_pkg::CAPACITY];
  lrutc_pkg::entry_t rdata;

  logic [lrutc_pkg::CNT_W-1:0]  count;
  logic [lrutc_pkg::CNT_W-1:0]  idx;
  logic [lrutc_pkg::CODE_W-1:0] code;
  lrutc_pkg::entry_t            carry;
  logic                         hit;
  logic                         evicted;
  logic [lrutc_pkg::CODE_W-1:0] evicted_code;
  logic [lrutc_pkg::IDX_W-1:0]  slot;

  logic [lrutc_pkg::CNT_W-1:0]  idx_next;
  logic                         out_free;
  logic                         match;

  logic                         we;
  logic [lrutc_pkg::IDX_W-1:0]  waddr;
  lrutc_pkg::entry_t            wdata;

  assign s_tready = (state == ST_IDLE);
  assign idx_next = idx + lrutc_pkg::CNT_W'(1);
  assign out_free = !m_tvalid || m_tready;
  assign match    = (rdata.code == code);

  // Write port: while scanning, the entry that was passed last moves into
  // the place just read; the tail write closes the gap at the end of a
  // non-full list; the front write places the requested entry.
  always_comb begin
    we    = 1'b0;
    waddr = idx[lrutc_pkg::IDX_W-1:0];
    wdata = carry;
    case (state)
      ST_CMP: begin
        we = (idx != '0);
      end
      ST_TAIL: begin
        we    = 1'b1;
        waddr = count[lrutc_pkg::IDX_W-1:0];
      end
      ST_FRONT: begin
        we         = out_free;
        waddr      = '0;
        wdata.code = code;
        wdata.slot = slot;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx[lrutc_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The front state reloads the output register itself when it is free.
      if (m_tvalid && m_tready && state != ST_FRONT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            code         <= s_tdata[lrutc_pkg::CODE_W-1:0];
            idx          <= '0;
            hit          <= 1'b0;
            evicted      <= 1'b0;
            evicted_code <= '0;
            if (count == '0) begin
              // Empty list: the first code takes slot zero.
              slot  <= '0;
              count <= lrutc_pkg::CNT_W'(1);
              state <= ST_FRONT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (match) begin
            hit   <= 1'b1;
            slot  <= rdata.slot;
            state <= ST_FRONT;
          end else begin
            carry <= rdata;
            if (idx_next == count) begin
              if (count == lrutc_pkg::CNT_W'(lrutc_pkg::CAPACITY)) begin
                // Full list: the oldest entry drops out and lends its slot.
                evicted      <= 1'b1;
                evicted_code <= rdata.code;
                slot         <= rdata.slot;
                state        <= ST_FRONT;
              end else begin
                state <= ST_TAIL;
              end
            end else begin
              idx   <= idx_next;
              state <= ST_READ;
            end
          end
        end
        ST_TAIL: begin
          slot  <= count[lrutc_pkg::IDX_W-1:0];
          count <= count + lrutc_pkg::CNT_W'(1);
          state <= ST_FRONT;
        end
        ST_FRONT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, evicted_code, evicted,
                         lrutc_pkg::SLOT_W'(slot), hit};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lrutc_pkg::CNT_W'(lrutc_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + lrutc_pkg::CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> !m_tdata[8])
    else $error("hit reported together with an eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (count == lrutc_pkg::CNT_W'(lrutc_pkg::CAPACITY)))
    else $error("eviction from a cache that is not full");

  a_evict_code_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[8]) |-> (m_tdata[29:9] == '0))
    else $error("evicted code set without an eviction");

endmodule

`default_nettype wire

// ----- tb/sv/tb_lru_move_to_front_tag_cache_unit.sv -----
// Self-checking testbench for the move-to-front LRU tag cache: directed and
// random bursts of code lookups against a local recency-list predictor.
// Depends on lrutc_pkg and lru_move_to_front_tag_cache_unit.
`timescale 1ns / 1ps

module tb_lru_move_to_front_tag_cache_unit;

  localparam int CODE_MAX       = (1 << lrutc_pkg::CODE_W) - 1;
  localparam int UNICODE_TOP    = 'h10FFFF;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int POOL_SIZE      = 200;
  localparam int DRAIN_CYCLES   = 2 * lrutc_pkg::CAPACITY + 16;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int REPORT_LIMIT   = 10;

  // Result beat layout, highest field first.
  typedef struct packed {
    logic [lrutc_pkg::OUT_W-lrutc_pkg::CODE_W-lrutc_pkg::SLOT_W-3:0] pad;
    logic [lrutc_pkg::CODE_W-1:0]                                    evicted_code;
    logic                                                            evicted;
    logic [lrutc_pkg::SLOT_W-1:0]                                    slot;
    logic                                                            hit;
  } lookup_result_t;

  typedef enum {PH_HOT_SET, PH_NEAR_FULL, PH_THRASH, PH_EXACT_FIT, PH_COLD} access_phase_t;
  typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [lrutc_pkg::IN_W-1:0]    s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [lrutc_pkg::OUT_W-1:0]   m_tdata;

  lru_move_to_front_tag_cache_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Stimulus and expectation stores.
  logic [lrutc_pkg::CODE_W-1:0] pending_codes[$];
  lookup_result_t               expected_results[$];
  logic [lrutc_pkg::CODE_W-1:0] code_pool[POOL_SIZE];

  // Mirror of the recency list, front first.
  lrutc_pkg::entry_t mirror_order[lrutc_pkg::CAPACITY];
  int                mirror_count = 0;

  // Run statistics.
  int n_lookups = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_above_unicode = 0;
  int deepest_hit = -1;
  int n_mismatches = 0;
  int idle_cycles = 0;
  logic in_beat_taken = 1'b0;

  // Sender burst state and receiver stall state.
  int       burst_left = 1;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_STREAM;
  int       rx_mode_left = 0;
  int       rx_phase = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Looks a code up in the mirrored recency list, moves or inserts it at the
  // front, and returns the result beat the block should produce.
  function automatic lookup_result_t lookup_and_update(logic [lrutc_pkg::CODE_W-1:0] code);
    lookup_result_t    r;
    lrutc_pkg::entry_t e;
    int                found;
    int                shift_n;
    r = '0;
    found = -1;
    for (int i = 0; i < mirror_count; i++) begin
      if (found < 0 && mirror_order[i].code == code) found = i;
    end
    if (found >= 0) begin
      e = mirror_order[found];
      shift_n = found;
      r.hit = 1'b1;
      n_hits++;
      if (found > deepest_hit) deepest_hit = found;
    end else if (mirror_count < lrutc_pkg::CAPACITY) begin
      e.code = code;
      e.slot = lrutc_pkg::IDX_W'(mirror_count);
      shift_n = mirror_count;
      mirror_count++;
    end else begin
      // Full cache: the back entry leaves and hands its slot to the new code.
      e.code = code;
      e.slot = mirror_order[lrutc_pkg::CAPACITY-1].slot;
      shift_n = lrutc_pkg::CAPACITY - 1;
      r.evicted = 1'b1;
      r.evicted_code = mirror_order[lrutc_pkg::CAPACITY-1].code;
      n_evictions++;
    end
    for (int j = shift_n; j > 0; j--) mirror_order[j] = mirror_order[j-1];
    mirror_order[0] = e;
    r.slot = lrutc_pkg::SLOT_W'(e.slot);
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      n_mismatches++;
      if (n_mismatches <= REPORT_LIMIT)
        $display("%0t: %s differs: expected 0x%0h, got 0x%0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Driver: presents queued codes in bursts of random length with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_codes.size() != 0) begin
        s_tdata  <= {{(lrutc_pkg::IN_W-lrutc_pkg::CODE_W){1'b0}}, pending_codes.pop_front()};
        s_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls follow a randomly chosen mode, chosen anew when its run counter expires.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left <= 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 300);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_STREAM: begin
          m_tready <= 1'b1;
        end
        RX_COIN: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_tready <= (rx_phase % 8) < 3;
        end
      endcase
    end
  end

  // Monitor: predicts on every accepted code, checks every accepted result,
  // and ends the run if the handshakes go quiet for too long.
  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (!rst) begin
      in_beat_taken <= s_tvalid && s_tready;
      // The result leaving now always belongs to an earlier lookup, so it is
      // checked before a code accepted on the same edge is predicted.
      if (m_tvalid && m_tready) begin
        got = lookup_result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          n_mismatches++;
          if (n_mismatches <= REPORT_LIMIT)
            $display("%0t: result beat 0x%0h with no lookup outstanding", $realtime, m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", int'(want.hit), int'(got.hit));
          check_field("slot", int'(want.slot), int'(got.slot));
          check_field("evicted", int'(want.evicted), int'(got.evicted));
          check_field("evicted_code", int'(want.evicted_code), int'(got.evicted_code));
        end
      end
      if (s_tvalid && s_tready) begin
        n_lookups++;
        if (s_tdata[lrutc_pkg::CODE_W-1:0] > UNICODE_TOP) n_above_unicode++;
        expected_results.push_back(lookup_and_update(s_tdata[lrutc_pkg::CODE_W-1:0]));
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d quiet cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    access_phase_t phase;
    int            phase_len;
    int            sweep;
    int            queued;

    // Pool codes are distinct: the low byte is the pool index.
    for (int i = 0; i < POOL_SIZE; i++)
      code_pool[i] = {(lrutc_pkg::CODE_W-8)'($urandom_range(0, 8191)), 8'(i)};

    // Directed opening: field extremes, codes past the Unicode range, hits at
    // the back and the front of a short list.
    pending_codes.push_back(lrutc_pkg::CODE_W'(0));
    pending_codes.push_back(lrutc_pkg::CODE_W'(CODE_MAX));
    pending_codes.push_back(lrutc_pkg::CODE_W'(UNICODE_TOP));
    pending_codes.push_back(lrutc_pkg::CODE_W'(UNICODE_TOP + 1));
    pending_codes.push_back(lrutc_pkg::CODE_W'(0));
    pending_codes.push_back(lrutc_pkg::CODE_W'(0));
    pending_codes.push_back(lrutc_pkg::CODE_W'(CODE_MAX));
    pending_codes.push_back(lrutc_pkg::CODE_W'('h155555));
    pending_codes.push_back(lrutc_pkg::CODE_W'('h0AAAAA));
    pending_codes.push_back(lrutc_pkg::CODE_W'('h155555));
    pending_codes.push_back(lrutc_pkg::CODE_W'(UNICODE_TOP));
    pending_codes.push_back(lrutc_pkg::CODE_W'(UNICODE_TOP + 1));

    // Random part in phases: hot working sets that mostly hit, sets just above
    // capacity, sweeps that defeat LRU or fit it exactly, and cold codes.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      phase     = access_phase_t'($urandom_range(0, 4));
      phase_len = $urandom_range(40, 160);
      sweep     = $urandom_range(0, POOL_SIZE - 1);
      for (int k = 0; k < phase_len && queued < RANDOM_ITEMS; k++) begin
        case (phase)
          PH_HOT_SET:
            pending_codes.push_back(code_pool[$urandom_range(0, 63)]);
          PH_NEAR_FULL:
            pending_codes.push_back(code_pool[$urandom_range(0, lrutc_pkg::CAPACITY + 11)]);
          PH_THRASH:
            pending_codes.push_back(code_pool[(sweep + k) % (lrutc_pkg::CAPACITY + 1)]);
          PH_EXACT_FIT:
            pending_codes.push_back(code_pool[(sweep + k) % lrutc_pkg::CAPACITY]);
          default:
            pending_codes.push_back(lrutc_pkg::CODE_W'($urandom & CODE_MAX));
        endcase
        queued++;
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_codes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d lookups: %0d hits (deepest at list position %0d), %0d evictions.",
             n_lookups, n_hits, deepest_hit, n_evictions);
    $display("%0d lookups used codes above the Unicode range.", n_above_unicode);
    if (n_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field mismatches in total", n_mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- lru_move_to_front_tag_cache_unit.f -----
rtl/lrutc_pkg.sv
rtl/lru_move_to_front_tag_cache_unit.sv
tb/sv/tb_lru_move_to_front_tag_cache_unit.sv
